@@ hw/rtl/bbb_pkg.sv @@
// Shared types, constants and helper functions for the block boundary blockiness unit.
// Depends on nothing; the queue, front end, back end, top level and checker import it.
`timescale 1ns / 1ps

package bbb_pkg;

	localparam int RGB_W     = 8;
	localparam int Y_W       = 24;
	localparam int SIZE_W    = 11;
	localparam int THR_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;
	localparam int Q_DEPTH   = 2;

	localparam logic [15:0] WEIGHT_R = 16'd19595;
	localparam logic [15:0] WEIGHT_G = 16'd38470;
	localparam logic [15:0] WEIGHT_B = 16'd7471;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATCH_ROWS       = 2'd0,
		CFG_PATCH_COLS       = 2'd1,
		CFG_CHECK_ENABLE     = 2'd2,
		CFG_BLOCKY_THRESHOLD = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_DIV  = 2'd1,
		B_DONE = 2'd2
	} back_state_t;

	typedef struct packed {
		logic [RGB_W-1:0] red;
		logic [RGB_W-1:0] green;
		logic [RGB_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [Y_W-1:0] avg_boundary_diff;
		logic           blocky;
	} result_t;

	// Occupancy of the job queue as seen by the front end.
	typedef struct packed {
		logic full;
		logic busy;
	} q_stat_t;

	function automatic logic [Y_W-1:0] luma(input pixel_t p);
		logic [Y_W-1:0] yr;
		logic [Y_W-1:0] yg;
		logic [Y_W-1:0] yb;
		yr = Y_W'(WEIGHT_R) * Y_W'(p.red);
		yg = Y_W'(WEIGHT_G) * Y_W'(p.green);
		yb = Y_W'(WEIGHT_B) * Y_W'(p.blue);
		return yr + yg + yb;
	endfunction

	function automatic logic [Y_W-1:0] abs_diff(input logic [Y_W-1:0] a,
		input logic [Y_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

@@ hw/rtl/bbb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the previous-row luminance store.
`timescale 1ns / 1ps

module bbb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/bbb_queue.sv @@
// Two-entry job queue between the pixel front end and the division back end.
// Depends on bbb_pkg for the queue depth and the status struct.
`timescale 1ns / 1ps

module bbb_queue
	import bbb_pkg::*;
#(
	parameter int WIDTH = 94
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data,
	output q_stat_t          stat
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_rd;

	assign do_rd      = rd_en && (count_q != '0);
	assign rd_valid   = (count_q != '0);
	assign rd_data    = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(Q_DEPTH));
	assign stat.busy  = (count_q != '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/bbb_front.sv @@
// Pixel front end: configuration registers, raster position tracking, luminance,
// boundary differences and the per-patch sums. Depends on bbb_pkg and bbb_ram.
`timescale 1ns / 1ps

module bbb_front
	import bbb_pkg::*;
#(
	parameter int BLOCK_SIZE = 8,
	parameter int MAX_COLS   = 1024,
	parameter int MAX_ROWS   = 1024,
	parameter int PAIR_W     = 22,
	parameter int SUM_W      = 46,
	parameter int JOB_W      = 93
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  pixel_t               pixel,
	input  logic                 push,
	output logic                 full,
	input  q_stat_t              q_stat,
	output logic                 job_push,
	output logic [JOB_W-1:0]     job_data
);

	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int COLS_EW = COL_W + 1;
	localparam int ROWS_EW = ROW_W + 1;
	localparam int BLK_W   = $clog2(BLOCK_SIZE);

	// Configuration registers
	logic [SIZE_W-1:0] rows_cfg_q;
	logic [SIZE_W-1:0] cols_cfg_q;
	logic              enable_q;
	logic [THR_W-1:0]  thr_q;

	// Raster position
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [BLK_W-1:0]  cblk_q;
	logic [BLK_W-1:0]  rblk_q;

	logic [COLS_EW-1:0] cols_eff;
	logic [ROWS_EW-1:0] rows_eff;
	logic               accept;
	logic               vb;
	logic               hb;
	logic               end_row;
	logic               last;
	logic               gate;
	logic [Y_W-1:0]     y0;

	// Stage 1
	logic               valid_s1;
	logic [Y_W-1:0]     y_s1;
	logic [COL_W-1:0]   col_s1;
	logic               vb_s1;
	logic               hb_s1;
	logic               byp_s1;
	logic               last_s1;
	logic               gate_s1;
	logic [THR_W-1:0]   thr_s1;

	logic [Y_W-1:0]     prev_q;
	logic [Y_W-1:0]     line_rd;
	logic [Y_W-1:0]     line_val;
	logic [Y_W-1:0]     dv;
	logic [Y_W-1:0]     dh;
	logic [SUM_W-1:0]   sum_q;
	logic [PAIR_W-1:0]  cnt_q;
	logic [SUM_W-1:0]   sum_next;
	logic [PAIR_W-1:0]  cnt_next;

	// Sizes of zero act as one; sizes above the maximum saturate.
	always_comb begin
		if (rows_cfg_q == '0) begin
			rows_eff = ROWS_EW'(1);
		end else if (32'(rows_cfg_q) > MAX_ROWS) begin
			rows_eff = ROWS_EW'(MAX_ROWS);
		end else begin
			rows_eff = ROWS_EW'(rows_cfg_q);
		end
		if (cols_cfg_q == '0) begin
			cols_eff = COLS_EW'(1);
		end else if (32'(cols_cfg_q) > MAX_COLS) begin
			cols_eff = COLS_EW'(MAX_COLS);
		end else begin
			cols_eff = COLS_EW'(cols_cfg_q);
		end
	end

	// A last pixel must always find room in the queue once it reaches stage 1,
	// so the one still in flight is counted against the free entries.
	assign full    = q_stat.full || (q_stat.busy && valid_s1 && last_s1);
	assign accept  = push && !full;
	assign y0      = luma(pixel);
	assign vb      = (col_q != '0) && (cblk_q == '0);
	assign hb      = (row_q != '0) && (rblk_q == '0);
	assign end_row = (COLS_EW'(col_q) + COLS_EW'(1)) >= cols_eff;
	assign last    = end_row && ((ROWS_EW'(row_q) + ROWS_EW'(1)) >= rows_eff);
	assign gate    = enable_q && (32'(rows_eff) >= BLOCK_SIZE) &&
		(32'(cols_eff) >= BLOCK_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= SIZE_W'(1024);
			cols_cfg_q <= SIZE_W'(1024);
			enable_q   <= 1'b1;
			thr_q      <= THR_W'(1179648);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PATCH_ROWS:       rows_cfg_q <= cfg_data[SIZE_W-1:0];
				CFG_PATCH_COLS:       cols_cfg_q <= cfg_data[SIZE_W-1:0];
				CFG_CHECK_ENABLE:     enable_q   <= cfg_data[0];
				CFG_BLOCKY_THRESHOLD: thr_q      <= cfg_data[THR_W-1:0];
				default:              enable_q   <= enable_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cblk_q <= '0;
			rblk_q <= '0;
		end else if (accept) begin
			if (end_row) begin
				col_q  <= '0;
				cblk_q <= '0;
				if (last) begin
					row_q  <= '0;
					rblk_q <= '0;
				end else begin
					row_q  <= row_q + 1'b1;
					rblk_q <= (rblk_q == BLK_W'(BLOCK_SIZE - 1)) ? '0 : rblk_q + 1'b1;
				end
			end else begin
				col_q  <= col_q + 1'b1;
				cblk_q <= (cblk_q == BLK_W'(BLOCK_SIZE - 1)) ? '0 : cblk_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			y_s1    <= y0;
			col_s1  <= col_q;
			vb_s1   <= vb;
			hb_s1   <= hb;
			// The RAM returns the old word when the item ahead writes the same column.
			byp_s1  <= valid_s1 && (col_s1 == col_q);
			last_s1 <= last;
			gate_s1 <= gate;
			thr_s1  <= thr_q;
		end
	end

	bbb_ram #(
		.WIDTH (Y_W),
		.DEPTH (MAX_COLS)
	) u_line_store (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (y_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (line_rd)
	);

	assign line_val = byp_s1 ? prev_q : line_rd;
	assign dv       = vb_s1 ? abs_diff(y_s1, prev_q) : '0;
	assign dh       = hb_s1 ? abs_diff(y_s1, line_val) : '0;
	assign sum_next = sum_q + SUM_W'(dv) + SUM_W'(dh);
	assign cnt_next = cnt_q + PAIR_W'(vb_s1) + PAIR_W'(hb_s1);
	assign job_push = valid_s1 && last_s1;
	assign job_data = {sum_next, cnt_next, gate_s1, thr_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else if (valid_s1) begin
			prev_q <= y_s1;
			if (last_s1) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
			end
		end
	end

endmodule

@@ hw/rtl/bbb_back.sv @@
// Back end: takes one patch job at a time, divides the difference sum by the pair
// count one quotient bit per cycle and holds the result. Depends on bbb_pkg.
`timescale 1ns / 1ps

module bbb_back
	import bbb_pkg::*;
#(
	parameter int PAIR_W = 22,
	parameter int SUM_W  = 46,
	parameter int JOB_W  = 93
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  logic [JOB_W-1:0] job_data,
	output logic             job_pop,
	output result_t          result,
	output logic             empty,
	input  logic             pop
);

	localparam int STEP_W = $clog2(SUM_W);

	back_state_t       state_q;
	back_state_t       state_d;
	logic              load_job;
	logic              div_step;
	logic              out_load;

	logic [SUM_W-1:0]  job_sum;
	logic [PAIR_W-1:0] job_cnt;
	logic              job_gate;
	logic [THR_W-1:0]  job_thr;
	logic              job_go;

	logic [SUM_W-1:0]  dvd_q;
	logic [PAIR_W-1:0] rem_q;
	logic [PAIR_W-1:0] div_q;
	logic [THR_W-1:0]  thr_q;
	logic [STEP_W-1:0] step_q;
	logic [PAIR_W:0]   rem_sh;
	logic [PAIR_W:0]   rem_sub;
	logic              ge;
	logic              flag;
	logic              out_valid_q;

	assign {job_sum, job_cnt, job_gate, job_thr} = job_data;
	assign job_go = job_gate && (job_cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		load_job = 1'b0;
		div_step = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					job_pop  = 1'b1;
					load_job = 1'b1;
					state_d  = job_go ? B_DIV : B_DONE;
				end
			end
			B_DIV: begin
				div_step = 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Restoring division: the dividend register fills with quotient bits from the right.
	assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
	assign ge      = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (load_job) begin
			dvd_q  <= job_go ? job_sum : '0;
			rem_q  <= '0;
			div_q  <= job_cnt;
			thr_q  <= job_thr;
			step_q <= '0;
		end else if (div_step) begin
			dvd_q  <= {dvd_q[SUM_W-2:0], ge};
			rem_q  <= ge ? rem_sub[PAIR_W-1:0] : rem_sh[PAIR_W-1:0];
			step_q <= step_q + 1'b1;
		end
	end

	// sum > thr * count exactly when the quotient beats the threshold, or ties
	// with it and leaves a remainder.
	assign flag = (dvd_q > SUM_W'(thr_q)) ||
		((dvd_q == SUM_W'(thr_q)) && (rem_q != '0));

	always_ff @(posedge clk) begin
		if (out_load) begin
			result.avg_boundary_diff <= dvd_q[Y_W-1:0];
			result.blocky            <= flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty = !out_valid_q;

endmodule

@@ hw/rtl/block_boundary_blockiness_unit.sv @@
// Top level of the block boundary blockiness unit: front end, job queue, back end.
// Depends on bbb_pkg, bbb_front, bbb_queue and bbb_back.
`timescale 1ns / 1ps

// Usage
// Pixels of a patch arrive in raster order on pixel, written with push while full
// is low; one pixel can be taken every cycle. The front end keeps a row of
// luminance in a RAM of MAX_COLS words and accumulates the boundary steps as the
// pixels pass.
// After the last pixel of a patch, its sum and pair count go through a two-entry
// queue to a bit-serial divider that produces one quotient bit per cycle. The
// result (average step and blocky flag) shows on result while empty is low.
// When the result is gated to zero the divider is skipped. The divider works on
// one patch at a time, which bounds the rate of patches.
// If the receiver does not pop, the result is held, the divider holds its next
// answer, the queue fills, and full is raised until room appears; pixels of the
// next patch continue to be taken as long as the queue has room for its end.
// Configuration goes through cfg_valid/cfg_index/cfg_data; cfg_ready is always
// high, and registers are meant to be written only while the block is idle.
// Reset clears positions, sums and queue, raises empty (result keeps its data),
// and restores the register defaults. The row RAM needs no clearing pass.

module block_boundary_blockiness_unit
	import bbb_pkg::*;
#(
	parameter int BLOCK_SIZE = 8,
	parameter int MAX_COLS   = 1024,
	parameter int MAX_ROWS   = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pixel_t               pixel,
	input  logic                 push,
	output logic                 full,
	output result_t              result,
	output logic                 empty,
	input  logic                 pop,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int PAIR_W = $clog2(2 * MAX_ROWS * MAX_COLS + 1);
	localparam int SUM_W  = PAIR_W + Y_W;
	localparam int JOB_W  = SUM_W + PAIR_W + 1 + THR_W;

	q_stat_t          q_stat;
	logic             job_push;
	logic [JOB_W-1:0] job_wdata;
	logic             job_valid;
	logic [JOB_W-1:0] job_rdata;
	logic             job_pop;

	assign cfg_ready = 1'b1;

	bbb_front #(
		.BLOCK_SIZE (BLOCK_SIZE),
		.MAX_COLS   (MAX_COLS),
		.MAX_ROWS   (MAX_ROWS),
		.PAIR_W     (PAIR_W),
		.SUM_W      (SUM_W),
		.JOB_W      (JOB_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.push      (push),
		.full      (full),
		.q_stat    (q_stat),
		.job_push  (job_push),
		.job_data  (job_wdata)
	);

	bbb_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_push),
		.wr_data  (job_wdata),
		.rd_en    (job_pop),
		.rd_valid (job_valid),
		.rd_data  (job_rdata),
		.stat     (q_stat)
	);

	bbb_back #(
		.PAIR_W (PAIR_W),
		.SUM_W  (SUM_W),
		.JOB_W  (JOB_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_data  (job_rdata),
		.job_pop   (job_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

@@ hw/rtl/bbb_checker.sv @@
// Port-level checks for the block boundary blockiness unit, bound to the top level.
// Depends on bbb_pkg for the result type.
`timescale 1ns / 1ps

module bbb_checker
	import bbb_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    full,
	input logic    pop,
	input logic    empty,
	input result_t result,
	input logic    cfg_ready
);

	// A result that is not taken stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed or vanished while stalled");

	// Nothing can be waiting straight after reset.
	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> empty)
		else $error("result present straight after reset");

	// The queue starts empty, so the input must be open after reset.
	a_open_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !full)
		else $error("input closed straight after reset");

	// Register writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind block_boundary_blockiness_unit bbb_checker u_bbb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.full      (full),
	.pop       (pop),
	.empty     (empty),
	.result    (result),
	.cfg_ready (cfg_ready)
);
